// File: src/hpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared types and constants for the histogram percentile level block.
// ----------------------------------------------------------------------------
package hpl_pkg;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  // Fixed port widths
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 17;
  localparam int CUT_W      = 8;
  localparam int PERMILLE_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_BINS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERMILLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PERMILLE = 2'd2;

  // Register reset values
  localparam logic [CUT_W-1:0]      CUT_BINS_RST      = 8'd5;
  localparam logic [PERMILLE_W-1:0] LOW_PERMILLE_RST  = 10'd98;
  localparam logic [PERMILLE_W-1:0] HIGH_PERMILLE_RST = 10'd990;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_CUT,
    ST_CUT_WAIT,
    ST_REM,
    ST_THR,
    ST_WALK,
    ST_DRAIN
  } hpl_state_t;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_CUT,
    MODE_WALK,
    MODE_SAMPLE
  } hpl_mode_t;

  typedef struct packed {
    logic      sample_acc;
    logic      sweep;
    hpl_mode_t sweep_mode;
    logic      calc_rem;
    logic      calc_thr;
    logic      load_out;
  } hpl_cmd_t;

  typedef struct packed {
    logic at_cut;
    logic at_last;
    logic busy;
  } hpl_status_t;

endpackage

// File: src/hpl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_ctrl
// Sequencer: clear pass, sample counting, cut sum, threshold set-up, walk.
// ----------------------------------------------------------------------------
module hpl_ctrl
  import hpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  input  logic        out_stall,
  input  hpl_status_t status,
  output logic        in_stall,
  output logic        out_valid,
  output hpl_cmd_t    cmd
);

  hpl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.sweep_mode = MODE_CLEAR;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_mode = MODE_CLEAR;
        if (status.at_last) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind) begin
            state_nxt = ST_CUT;
          end else begin
            cmd.sample_acc = 1'b1;
          end
        end
      end
      ST_CUT: begin
        if (status.at_cut) begin
          state_nxt = ST_CUT_WAIT;
        end else begin
          cmd.sweep      = 1'b1;
          cmd.sweep_mode = MODE_CUT;
        end
      end
      ST_CUT_WAIT: begin
        if (!status.busy) begin
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        cmd.calc_rem = 1'b1;
        state_nxt    = ST_THR;
      end
      ST_THR: begin
        cmd.calc_thr = 1'b1;
        state_nxt    = ST_WALK;
      end
      ST_WALK: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_mode = MODE_WALK;
        if (status.at_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy && !out_valid_r) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/hpl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_datapath
// Histogram memory with forwarded increment, cut sum, thresholds and walk.
// ----------------------------------------------------------------------------
module hpl_datapath
  import hpl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpl_cmd_t              cmd,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [CUT_W-1:0]      cut_bins,
  input  logic [PERMILLE_W-1:0] low_permille,
  input  logic [PERMILLE_W-1:0] high_permille,
  output hpl_status_t           status,
  output logic [LEVEL_W-1:0]    out_low_level,
  output logic [LEVEL_W-1:0]    out_high_level
);

  localparam int DEPTH = 1 << SAMPLE_BITS;
  localparam int LVL_W = SAMPLE_BITS + 1;
  localparam int SCL_W = COUNT_BITS + PERMILLE_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0]  mem [DEPTH];

  logic [SAMPLE_BITS-1:0] sweep_addr_r;
  logic [SAMPLE_BITS-1:0] rd_addr;
  logic [COUNT_BITS-1:0]  rd_data_r;
  logic                   wr_en;
  logic [SAMPLE_BITS-1:0] wr_addr;
  logic [COUNT_BITS-1:0]  wr_data;

  logic                   s1_v_r;
  hpl_mode_t              s1_mode_r;
  logic [SAMPLE_BITS-1:0] s1_addr_r;
  logic                   fw_v_r;
  logic [SAMPLE_BITS-1:0] fw_addr_r;
  logic [COUNT_BITS-1:0]  fw_data_r;
  logic [COUNT_BITS-1:0]  base;
  logic [COUNT_BITS-1:0]  incr;
  logic                   samp_wr;

  logic [COUNT_BITS-1:0]  total_r;
  logic [COUNT_BITS-1:0]  cut_sum_r;
  logic [COUNT_BITS-1:0]  rem_r;
  logic [COUNT_BITS-1:0]  acc_r;
  logic [COUNT_BITS:0]    cut_sum_add;
  logic [COUNT_BITS:0]    acc_add;
  logic [SCL_W-1:0]       lo_prod;
  logic [SCL_W-1:0]       lo_thr_r;
  logic [SCL_W-1:0]       hi_thr_r;
  logic [SCL_W-1:0]       acc_ext;

  logic                   s2_v_r;
  logic                   s3_v_r;
  logic [SCL_W-1:0]       scaled_r;
  logic [LVL_W-1:0]       k_r;
  logic                   lo_found_r;
  logic                   hi_found_r;
  logic [LVL_W-1:0]       lo_r;
  logic [LVL_W-1:0]       hi_r;
  logic [LVL_W-1:0]       n_lvl;
  logic [LVL_W-1:0]       out_low_r;
  logic [LVL_W-1:0]       out_high_r;

  // Memory port selection
  assign rd_addr = cmd.sweep ? sweep_addr_r : in_sample[SAMPLE_BITS-1:0];
  assign base    = (fw_v_r && fw_addr_r == s1_addr_r) ? fw_data_r : rd_data_r;
  assign incr    = (base == COUNT_MAX) ? COUNT_MAX : base + COUNT_BITS'(1);
  assign samp_wr = s1_v_r && s1_mode_r == MODE_SAMPLE;
  assign wr_en   = samp_wr || cmd.sweep;
  assign wr_addr = samp_wr ? s1_addr_r : sweep_addr_r;
  assign wr_data = samp_wr ? incr : '0;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Saturating sums
  assign cut_sum_add = {1'b0, cut_sum_r} + {1'b0, rd_data_r};
  assign acc_add     = {1'b0, acc_r} + {1'b0, rd_data_r};
  assign lo_prod     = SCL_W'(low_permille) * SCL_W'(rem_r);
  assign acc_ext     = SCL_W'(acc_r);
  assign n_lvl       = LVL_W'(DEPTH) - LVL_W'(cut_bins);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      fw_v_r       <= 1'b0;
      total_r      <= '0;
      cut_sum_r    <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr_r <= sweep_addr_r + SAMPLE_BITS'(1);
      end
      s1_v_r <= cmd.sample_acc ||
                (cmd.sweep && (cmd.sweep_mode == MODE_CUT || cmd.sweep_mode == MODE_WALK));
      s2_v_r <= s1_v_r && s1_mode_r == MODE_WALK;
      s3_v_r <= s2_v_r;
      fw_v_r <= samp_wr;

      if (cmd.sample_acc) begin
        total_r <= (total_r == COUNT_MAX) ? COUNT_MAX : total_r + COUNT_BITS'(1);
      end else if (cmd.calc_rem) begin
        total_r <= '0;
      end

      if (s1_v_r && s1_mode_r == MODE_CUT) begin
        cut_sum_r <= cut_sum_add[COUNT_BITS] ? COUNT_MAX : cut_sum_add[COUNT_BITS-1:0];
      end else if (cmd.calc_rem) begin
        cut_sum_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= cmd.sample_acc ? MODE_SAMPLE : cmd.sweep_mode;
    s1_addr_r <= rd_addr;
    fw_addr_r <= s1_addr_r;
    fw_data_r <= incr;

    if (cmd.calc_rem) begin
      rem_r <= (total_r > cut_sum_r) ? total_r - cut_sum_r : '0;
    end

    // Thresholds and walk start; level 0 is met only by a zero threshold
    if (cmd.calc_thr) begin
      lo_thr_r   <= lo_prod;
      hi_thr_r   <= SCL_W'(high_permille) * SCL_W'(rem_r);
      acc_r      <= '0;
      k_r        <= LVL_W'(1);
      lo_found_r <= (lo_prod == '0);
      lo_r       <= '0;
      hi_found_r <= 1'b0;
      hi_r       <= '0;
    end else begin
      if (s1_v_r && s1_mode_r == MODE_WALK) begin
        acc_r <= acc_add[COUNT_BITS] ? COUNT_MAX : acc_add[COUNT_BITS-1:0];
      end
      if (s3_v_r) begin
        k_r <= k_r + LVL_W'(1);
        if (!lo_found_r && scaled_r >= lo_thr_r) begin
          lo_found_r <= 1'b1;
          lo_r       <= k_r;
        end
        if (!hi_found_r && scaled_r >= hi_thr_r) begin
          hi_found_r <= 1'b1;
          hi_r       <= k_r;
        end
      end
    end

    // acc * 1000 as shift and subtract
    if (s2_v_r) begin
      scaled_r <= (acc_ext << 10) - (acc_ext << 4) - (acc_ext << 3);
    end

    if (cmd.load_out) begin
      out_low_r  <= lo_found_r ? lo_r : n_lvl;
      out_high_r <= hi_found_r ? hi_r : n_lvl;
    end
  end

  assign status.at_cut  = (sweep_addr_r == SAMPLE_BITS'(cut_bins));
  assign status.at_last = &sweep_addr_r;
  assign status.busy    = s1_v_r || s2_v_r || s3_v_r;

  assign out_low_level  = LEVEL_W'(out_low_r);
  assign out_high_level = LEVEL_W'(out_high_r);

endmodule

// File: src/histogram_percentile_levels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_percentile_levels
// Sample histogram with per-mille clip level search.
// ----------------------------------------------------------------------------
// Sample items (kind 0) are counted into a 2^SAMPLE_BITS bin histogram, one
// item per cycle while in_stall is low, by a read-modify-write on a memory
// with one read and one write port and a forwarding path from the last
// write. A finish item (kind 1) stalls the input and starts a walk: bins
// below cut_bins are summed, the remaining total and both per-mille
// thresholds are formed, then bins cut_bins up to the top are read in turn
// and the running sum is tested against both thresholds in a three-stage
// pipe. Every bin read by the walk is zeroed as it goes, so the histogram is
// empty again when the walk ends. The walk is paced by the one read port,
// and a finish gives one result item. The result sits in an output register;
// samples are accepted again while it waits. After reset a clearing pass
// over all 2^SAMPLE_BITS bins runs before the first item is taken;
// configuration writes are taken throughout.
// Counters and sums saturate at 2^COUNT_BITS - 1.
// ----------------------------------------------------------------------------
module histogram_percentile_levels
  import hpl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [SAMPLE_W-1:0]   in_sample,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    out_low_level,
  output logic [LEVEL_W-1:0]    out_high_level,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CUT_W-1:0]      cut_bins_r;
  logic [PERMILLE_W-1:0] low_permille_r;
  logic [PERMILLE_W-1:0] high_permille_r;

  hpl_cmd_t    cmd;
  hpl_status_t status;

  // Configuration registers; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_bins_r      <= CUT_BINS_RST;
      low_permille_r  <= LOW_PERMILLE_RST;
      high_permille_r <= HIGH_PERMILLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CUT_BINS:      cut_bins_r      <= cfg_wdata[CUT_W-1:0];
        CFG_LOW_PERMILLE:  low_permille_r  <= cfg_wdata[PERMILLE_W-1:0];
        CFG_HIGH_PERMILLE: high_permille_r <= cfg_wdata[PERMILLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  hpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Histogram memory and level search
  hpl_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_sample      (in_sample),
    .cut_bins       (cut_bins_r),
    .low_permille   (low_permille_r),
    .high_permille  (high_permille_r),
    .status         (status),
    .out_low_level  (out_low_level),
    .out_high_level (out_high_level)
  );

endmodule

// File: dv/histogram_percentile_levels_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_percentile_levels_test
// Self-checking bench for the histogram percentile level block.
// ----------------------------------------------------------------------------
// Sample items are streamed into the block and mirrored into a local
// histogram. Every finish item runs the same walk on that histogram and
// queues the expected low and high levels. Each result item is checked
// field by field against the oldest queued pair. A short directed plan
// covers the empty histogram, both sample extremes, masked register writes
// and thresholds that can never be met. Random phases then vary the
// registers, the sample spread and the idling on both channels. One phase
// holds the output off for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module histogram_percentile_levels_test;
  import hpl_pkg::*;

  localparam int BINS = 1 << SAMPLE_BITS_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Stop points for the random part; each finish walks the whole histogram,
  // so the finish count dominates run time
  localparam int TARGET_SAMPLES  = 1760;
  localparam int TARGET_FINISHES = 32;
  localparam int PRESSURE_PHASE  = 2;
  localparam int HOLD_CYCLES     = 150000;
  // cycles allowed for samples still in the counting pipe
  localparam int SETTLE_CYCLES   = 32;
  localparam int unsigned CYCLE_LIMIT = 12_000_000;

  typedef struct packed {
    logic [LEVEL_W-1:0] low;
    logic [LEVEL_W-1:0] high;
  } levels_t;

  typedef enum logic [1:0] {
    PLAN_SAMPLE,
    PLAN_FINISH,
    PLAN_CFG
  } plan_op_t;

  typedef struct packed {
    plan_op_t               op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [SAMPLE_W-1:0]    value;
    logic                   typed;   // expected levels written in the row
    levels_t                levels;
  } plan_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // DUT connections; every input known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_kind = 1'b0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEVEL_W-1:0]    out_low_level;
  logic [LEVEL_W-1:0]    out_high_level;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the histogram and registers
  longint unsigned       bin_tally [0:BINS-1];
  longint unsigned       sample_total;
  logic [CUT_W-1:0]      cut_cfg;
  logic [PERMILLE_W-1:0] low_pm_cfg;
  logic [PERMILLE_W-1:0] high_pm_cfg;

  levels_t               levels_due [$];
  levels_t               oldest_due;
  plan_row_t             directed_plan [$];

  int                    send_gap_pct = 0;
  int                    recv_stall_pct = 0;
  logic                  hold_go = 1'b0;
  logic                  hold_on = 1'b0;
  int unsigned           cycle_count = 0;
  int                    errors = 0;
  int                    sample_items = 0;
  int                    finish_items = 0;
  int                    results_seen = 0;

  histogram_percentile_levels uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_low_level  (out_low_level),
    .out_high_level (out_high_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Level prediction
  // ---------------------------------------------------------------------------
  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > COUNT_MAX) ? COUNT_MAX : s;
  endfunction

  // per-mille threshold by cross multiplication; an empty remainder always passes
  function automatic bit level_met(longint unsigned acc, longint unsigned pm,
                                   longint unsigned rem);
    return acc * 64'd1000 >= pm * rem;
  endfunction

  function automatic void count_sample(logic [SAMPLE_W-1:0] smp);
    bin_tally[smp] = sat_sum(bin_tally[smp], 64'd1);
    sample_total   = sat_sum(sample_total, 64'd1);
  endfunction

  // Walk from the cut upward; the low count tests before each bin, the high
  // count after, so high is never below one. Histogram is empty afterwards.
  function automatic levels_t walk_levels();
    longint unsigned cut_sum;
    longint unsigned rem;
    longint unsigned acc;
    int unsigned     span;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     i;
    levels_t         res;
    cut_sum = 0;
    for (i = 0; i < cut_cfg; i++) begin
      cut_sum = sat_sum(cut_sum, bin_tally[i]);
    end
    rem  = (sample_total > cut_sum) ? sample_total - cut_sum : 0;
    span = BINS - cut_cfg;
    lo  = 0;
    acc = 0;
    while (lo < span && !level_met(acc, low_pm_cfg, rem)) begin
      acc = sat_sum(acc, bin_tally[cut_cfg + lo]);
      lo++;
    end
    hi  = 0;
    acc = 0;
    do begin
      acc = sat_sum(acc, bin_tally[cut_cfg + hi]);
      hi++;
    end while (hi < span && !level_met(acc, high_pm_cfg, rem));
    res.low  = lo[LEVEL_W-1:0];
    res.high = hi[LEVEL_W-1:0];
    for (i = 0; i < BINS; i++) begin
      bin_tally[i] = 0;
    end
    sample_total = 0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel
  // ---------------------------------------------------------------------------
  // Valid is left high after acceptance unless a gap is drawn, so the next
  // call in the same step just replaces the payload.
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] smp,
                           input logic typed, input levels_t typed_levels);
    levels_t walked;
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_SAMPLE) begin
      count_sample(smp);
      sample_items++;
    end else begin
      walked = walk_levels();
      levels_due.push_back(typed ? typed_levels : walked);
      finish_items++;
    end
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
  endtask

  // One image: a spread of samples then its finish item
  task automatic send_image(input int unsigned n_samples);
    logic [SAMPLE_W-1:0] centre;
    logic [SAMPLE_W-1:0] smp;
    int unsigned         k;
    centre = SAMPLE_W'($urandom_range(0, 16'hFFFF));
    for (k = 0; k < n_samples; k++) begin
      case ($urandom_range(0, 3))
        0:       smp = SAMPLE_W'($urandom_range(0, 16'hFFFF));
        1:       smp = SAMPLE_W'($urandom_range(0, cut_cfg + 16));   // around the cut
        2:       smp = SAMPLE_W'(centre + $urandom_range(0, 255));   // narrow peak
        default: smp = SAMPLE_W'(16'hFFFF - $urandom_range(0, 31));  // top of range
      endcase
      send_item(KIND_SAMPLE, smp, 1'b0, '0);
    end
    send_item(KIND_FINISH, SAMPLE_W'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
  endtask

  // Quiet the input and let every result and any trailing sample drain
  task automatic settle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_CUT_BINS:      cut_cfg     = data[CUT_W-1:0];
      CFG_LOW_PERMILLE:  low_pm_cfg  = data[PERMILLE_W-1:0];
      CFG_HIGH_PERMILLE: high_pm_cfg = data[PERMILLE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [PERMILLE_W-1:0] pick_permille();
    case ($urandom_range(0, 5))
      0:       return PERMILLE_W'(0);
      1:       return PERMILLE_W'(1000);
      2:       return PERMILLE_W'(1023);          // never met once data exists
      3, 4:    return PERMILLE_W'($urandom_range(0, 1000));
      default: return PERMILLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [CUT_W-1:0] pick_cut();
    case ($urandom_range(0, 3))
      0:       return CUT_W'(0);
      1:       return CUT_W'(255);
      2:       return CUT_W'($urandom_range(0, 8));
      default: return CUT_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_row(input plan_op_t op, input logic [CFG_IDX_W-1:0] idx,
                         input logic [SAMPLE_W-1:0] value, input logic typed,
                         input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi);
    plan_row_t row;
    row.op          = op;
    row.idx         = idx;
    row.value       = value;
    row.typed       = typed;
    row.levels.low  = lo;
    row.levels.high = hi;
    directed_plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: check at acceptance, then draw the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        $display("%0t: result with nothing expected, low %0d high %0d",
                 $time, out_low_level, out_high_level);
        errors++;
      end else begin
        oldest_due = levels_due.pop_front();
        results_seen++;
        if (out_low_level !== oldest_due.low) begin
          $display("%0t: low_level expected %0d, got %0d",
                   $time, oldest_due.low, out_low_level);
          errors++;
        end
        if (out_high_level !== oldest_due.high) begin
          $display("%0t: high_level expected %0d, got %0d",
                   $time, oldest_due.high, out_high_level);
          errors++;
        end
      end
    end
    out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Long output hold-off, counted here so the sender keeps pushing meanwhile
  initial begin : output_hold
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, levels_due.size());
    $display("histogram_percentile_levels test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t  row;
    logic       prev_cfg;
    int         phase_no;
    int         n_img;
    idle_mode_t mode;

    sample_total = 0;
    cut_cfg      = CUT_BINS_RST;
    low_pm_cfg   = LOW_PERMILLE_RST;
    high_pm_cfg  = HIGH_PERMILLE_RST;

    // Directed plan. Typed rows: empty histogram gives low 0 / high 1, and a
    // per-mille of 1023 over real data runs to the top of the range.
    add_row(PLAN_FINISH, '0, 16'h0000, 1'b1, 17'd0, 17'd1);
    add_row(PLAN_SAMPLE, '0, 16'h0000, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'hFFFF, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'h5555, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'hAAAA, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'h0004, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'h0005, 1'b0, '0, '0);
    add_row(PLAN_FINISH, '0, 16'hFFFF, 1'b0, '0, '0);    // sample field ignored
    add_row(PLAN_CFG, CFG_CUT_BINS,      16'h0300, 1'b0, '0, '0);  // upper bits drop
    add_row(PLAN_CFG, CFG_LOW_PERMILLE,  16'd1023, 1'b0, '0, '0);
    add_row(PLAN_CFG, CFG_HIGH_PERMILLE, 16'd1023, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'h0000, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'hFFFF, 1'b0, '0, '0);
    add_row(PLAN_FINISH, '0, 16'h0000, 1'b1, 17'd65536, 17'd65536);
    add_row(PLAN_CFG, CFG_CUT_BINS,      16'd255,  1'b0, '0, '0);
    add_row(PLAN_CFG, CFG_LOW_PERMILLE,  16'd0,    1'b0, '0, '0);
    add_row(PLAN_CFG, CFG_HIGH_PERMILLE, 16'd1000, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'd255,  1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'hFFFF, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'd300,  1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'd254,  1'b0, '0, '0);   // just below the cut
    add_row(PLAN_FINISH, '0, 16'h0000, 1'b0, '0, '0);
    add_row(PLAN_CFG, CFG_CUT_BINS,      16'd0,    1'b0, '0, '0);
    add_row(PLAN_CFG, CFG_LOW_PERMILLE,  16'd1000, 1'b0, '0, '0);
    add_row(PLAN_CFG, CFG_HIGH_PERMILLE, 16'd0,    1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'd0, 1'b0, '0, '0);
    add_row(PLAN_SAMPLE, '0, 16'd7, 1'b0, '0, '0);
    add_row(PLAN_FINISH, '0, 16'h0000, 1'b0, '0, '0);
    add_row(PLAN_FINISH, '0, 16'h1234, 1'b1, 17'd0, 17'd1);  // straight after a walk

    // Synchronous reset; the block then clears its histogram before taking items
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    prev_cfg = 1'b0;
    foreach (directed_plan[r]) begin
      row = directed_plan[r];
      if (row.op == PLAN_CFG) begin
        if (!prev_cfg) settle();
        write_reg(row.idx, row.value[CFG_DATA_W-1:0]);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        send_item(row.op == PLAN_FINISH ? KIND_FINISH : KIND_SAMPLE, row.value,
                  row.typed, row.levels);
        prev_cfg = 1'b0;
      end
    end

    // Random phases: fresh registers, then a few images under one idling mode
    phase_no = 0;
    while (sample_items < TARGET_SAMPLES || finish_items < TARGET_FINISHES) begin
      settle();
      write_reg(CFG_CUT_BINS, {2'($urandom_range(0, 3)), pick_cut()});
      write_reg(CFG_LOW_PERMILLE, pick_permille());
      write_reg(CFG_HIGH_PERMILLE, pick_permille());
      cfg_we <= 1'b0;

      mode = idle_mode_t'(phase_no % 4);
      case (mode)
        IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_gap_pct = 47; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 47; end
        default:       begin send_gap_pct = 28; recv_stall_pct = 28; end
      endcase

      if (phase_no == PRESSURE_PHASE) begin
        // results pile up behind the held output until the input stalls
        send_gap_pct = 0;
        hold_go      = 1'b1;
        repeat (3) send_image($urandom_range(16, 48));
      end else begin
        n_img = $urandom_range(1, 3);
        repeat (n_img) begin
          if ($urandom_range(0, 9) == 0) send_image(0);
          else send_image($urandom_range(1, 140));
        end
      end
      phase_no++;
    end

    settle();

    $display("covered %0d samples and %0d finishes over %0d random phases",
             sample_items, finish_items, phase_no);
    $display("%0d level pairs checked, register extremes and a long output hold-off, %0d cycles",
             results_seen, cycle_count);
    if (errors == 0) begin
      $display("histogram_percentile_levels test passed");
    end else begin
      $display("histogram_percentile_levels test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/hpl_pkg.sv
src/hpl_ctrl.sv
src/hpl_datapath.sv
src/histogram_percentile_levels.sv
dv/histogram_percentile_levels_test.sv
